// ----- hw/rtl/pcrm_pkg.sv -----
package pcrm_pkg;

	localparam int DATA_WIDTH_DEF     = 16;
	localparam int GAIN_FRAC_BITS_DEF = 24;

	localparam int GAIN_W     = 32;
	localparam int RANGE_W    = 16;
	localparam int DRIVE_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// clamp bounds in whole units
	localparam int P_LIM_INT      = 1000;
	localparam int I_LIM_INT      = 100;
	localparam int I_PROD_LIM_INT = 200;
	localparam int D_LIM_INT      = 1000;
	localparam int SUM_LIM_INT    = 1000;

	// range mapping: t in -1000..1000, divide by 1000 through a reciprocal
	localparam int MAP_FULL  = 1000;
	localparam int MAP_U_W   = 10;
	localparam int MAP_X_W   = MAP_U_W + RANGE_W;
	localparam int MAP_SHIFT = 36;
	localparam logic [MAP_X_W:0] MAP_RECIP = (MAP_X_W + 1)'((64'd1 << MAP_SHIFT) / MAP_FULL);

	localparam logic [GAIN_W-1:0]  KP_RESET  = 32'd16777216;
	localparam logic [GAIN_W-1:0]  KI_RESET  = 32'd1678;
	localparam logic [GAIN_W-1:0]  KD_RESET  = 32'd167772;
	localparam logic [RANGE_W-1:0] POS_RESET = 16'd255;
	localparam logic [RANGE_W-1:0] NEG_RESET = 16'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_KP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG = 3'd4;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_SAT,
		ST_SUM,
		ST_NORM,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_MAP_FIX,
		ST_FINAL
	} state_t;

endpackage

// ----- hw/rtl/pcrm_mul.sv -----
module pcrm_mul #(
	parameter int A_W = 32,
	parameter int B_W = 17
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod
);

	logic [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
	end

	assign prod = prod_q;

endmodule

// ----- hw/rtl/pid_clamped_range_map.sv -----
// Clamped discrete PID controller with linear range mapping.
//
// Input channel (in_valid/in_ready) carries setpoint and measurement; each
// transfer yields exactly one drive value on the output channel
// (out_valid/out_ready). The previous error and the integral are kept across
// items. P, I and D terms are each formed by two passes of one shared
// 32 x 10 multiplier (low and high half of the error magnitude, or of the
// error difference magnitude for D), then saturated; the same multiplier
// scales the clamped sum onto pos_range or neg_range.
// out_valid rises once the three term passes, the sum, the normalization
// and the mapping steps are done. in_ready is high only while the sequencer
// is idle, so a new item is taken only after the previous drive has entered
// the output register. A finished drive waits in the output register; a
// following item may be taken meanwhile and holds in its last step until the register is free.
// Configuration writes (cfg_valid/cfg_ready) are always taken; unknown
// indexes are dropped. Reset restores the default gains and ranges and
// clears the integral and the previous error.
module pid_clamped_range_map #(
	parameter int DATA_WIDTH     = pcrm_pkg::DATA_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pcrm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        setpoint,
	input  logic signed [DATA_WIDTH-1:0]        measurement,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pcrm_pkg::DRIVE_W-1:0] drive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import pcrm_pkg::*;

	localparam int ERR_W  = DATA_WIDTH + 1;
	localparam int MAG_W  = DATA_WIDTH + 2;
	localparam int HALF_W = (MAG_W + 1) / 2;
	localparam int MB_W   = (HALF_W > MAP_U_W) ? HALF_W : MAP_U_W;
	localparam int PROD_W = GAIN_W + MB_W;
	localparam int ACC_W  = GAIN_W + 2 * HALF_W;
	localparam int LIM_W  = GAIN_FRAC_BITS + 10;
	localparam int TERM_W = LIM_W + 1;
	localparam int SUM_W  = LIM_W + 3;
	localparam int CMP_W  = (ACC_W > LIM_W) ? ACC_W : LIM_W;
	localparam int RCP_W  = 2 * MAP_X_W + 1;

	localparam logic [LIM_W-1:0] P_LIM  = LIM_W'(P_LIM_INT) << GAIN_FRAC_BITS;
	localparam logic [LIM_W-1:0] IP_LIM = LIM_W'(I_PROD_LIM_INT) << GAIN_FRAC_BITS;
	localparam logic [LIM_W-1:0] D_LIM  = LIM_W'(D_LIM_INT) << GAIN_FRAC_BITS;
	localparam logic signed [TERM_W:0] I_LIM = (TERM_W + 1)'(I_LIM_INT) << GAIN_FRAC_BITS;
	localparam logic [SUM_W-1:0] SUM_LIM = SUM_W'(SUM_LIM_INT) << GAIN_FRAC_BITS;

	state_t state_q, state_d;
	term_t  term_q;

	logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
	logic [RANGE_W-1:0] pos_q, neg_q;

	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [TERM_W-1:0] integral_q;
	logic                     out_valid_q;

	logic [MAG_W-1:0]         err_mag_q, diff_mag_q;
	logic                     err_neg_q, diff_neg_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [TERM_W-1:0] p_term_q, d_term_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [MAP_U_W-1:0]       t_mag_q;
	logic                     t_neg_q;
	logic [MAP_X_W-1:0]       x_q;
	logic [RANGE_W-1:0]       qe_q, q_q;
	logic signed [DRIVE_W-1:0] drive_q;

	logic in_xfer, fin_load;

	// input stage arithmetic
	logic signed [ERR_W-1:0] err;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        err_mag, diff_mag;

	// shared multiplier
	logic [GAIN_W-1:0]   mul_a;
	logic [MB_W-1:0]     mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [MAG_W-1:0]    mag_sel;
	logic [2*HALF_W-1:0] mag_pad;
	logic [GAIN_W-1:0]   gain_sel;
	logic [MAP_U_W-1:0]  map_u;
	logic [RANGE_W-1:0]  map_r;

	// saturation of one term
	logic [LIM_W-1:0]         lim_sel, sat_mag;
	logic                     term_neg;
	logic signed [TERM_W-1:0] term_val;
	logic signed [TERM_W:0]   isum, isum_sat;

	// normalization and mapping
	logic [SUM_W-1:0]   sum_abs, sum_sat;
	logic [RCP_W-1:0]   rcp_prod;
	logic [MAP_X_W-1:0] rem;
	logic [RANGE_W-1:0] q_fix;

	assign in_xfer   = in_valid && in_ready;
	assign fin_load  = (state_q == ST_FINAL) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	assign err      = ERR_W'(setpoint) - ERR_W'(measurement);
	assign diff     = MAG_W'(err) - MAG_W'(prev_err_q);
	assign err_mag  = MAG_W'(err[ERR_W-1] ? -err : err);
	assign diff_mag = diff[MAG_W-1] ? -diff : diff;

	assign mag_sel = (term_q == TERM_D) ? diff_mag_q : err_mag_q;
	assign mag_pad = (2 * HALF_W)'(mag_sel);
	assign map_u   = t_neg_q ? MAP_U_W'(MAP_FULL) - t_mag_q : t_mag_q;
	assign map_r   = t_neg_q ? neg_q : pos_q;

	always_comb begin
		case (term_q)
			TERM_P:  begin gain_sel = kp_q; lim_sel = P_LIM;  end
			TERM_I:  begin gain_sel = ki_q; lim_sel = IP_LIM; end
			default: begin gain_sel = kd_q; lim_sel = D_LIM;  end
		endcase
	end

	pcrm_mul #(
		.A_W(GAIN_W),
		.B_W(MB_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(mul_p)
	);

	// exact product magnitude, saturated to the term's bound
	always_comb begin
		sat_mag  = (CMP_W'(acc_q) > CMP_W'(lim_sel)) ? lim_sel : LIM_W'(acc_q);
		term_neg = (term_q == TERM_D) ? diff_neg_q : err_neg_q;
		term_val = term_neg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
		isum     = (TERM_W + 1)'(integral_q) + (TERM_W + 1)'(term_val);
		if (isum > I_LIM) begin
			isum_sat = I_LIM;
		end else if (isum < -I_LIM) begin
			isum_sat = -I_LIM;
		end else begin
			isum_sat = isum;
		end
	end

	always_comb begin
		sum_abs  = SUM_W'(sum_q[SUM_W-1] ? -sum_q : sum_q);
		sum_sat  = (sum_abs > SUM_LIM) ? SUM_LIM : sum_abs;
		rcp_prod = RCP_W'(MAP_X_W'(mul_p)) * RCP_W'(MAP_RECIP);
		rem      = x_q - MAP_X_W'(qe_q) * MAP_X_W'(MAP_FULL);
		q_fix    = (rem >= MAP_X_W'(MAP_FULL)) ? qe_q + 1'b1 : qe_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_xfer) state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_ACC;
			ST_ACC:     state_d = ST_SAT;
			ST_SAT:     state_d = (term_q == TERM_D) ? ST_SUM : ST_MUL_LO;
			ST_SUM:     state_d = ST_NORM;
			ST_NORM:    state_d = ST_MAP_MUL;
			ST_MAP_MUL: state_d = ST_MAP_DIV;
			ST_MAP_DIV: state_d = ST_MAP_FIX;
			ST_MAP_FIX: state_d = ST_FINAL;
			ST_FINAL:   if (fin_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MUL_LO: begin
				mul_a = gain_sel;
				mul_b = MB_W'(mag_pad[HALF_W-1:0]);
			end
			ST_MUL_HI: begin
				mul_a = gain_sel;
				mul_b = MB_W'(mag_pad[2*HALF_W-1:HALF_W]);
			end
			ST_MAP_MUL: begin
				mul_a = GAIN_W'(map_r);
				mul_b = MB_W'(map_u);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= TERM_P;
			out_valid_q <= 1'b0;
			prev_err_q  <= '0;
			integral_q  <= '0;
			kp_q        <= KP_RESET;
			ki_q        <= KI_RESET;
			kd_q        <= KD_RESET;
			pos_q       <= POS_RESET;
			neg_q       <= NEG_RESET;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				term_q     <= TERM_P;
				prev_err_q <= err;
			end else if (state_q == ST_SAT) begin
				case (term_q)
					TERM_P:  term_q <= TERM_I;
					TERM_I:  term_q <= TERM_D;
					default: term_q <= term_q;
				endcase
			end
			if (state_q == ST_SAT && term_q == TERM_I) begin
				integral_q <= TERM_W'(isum_sat);
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_KP:  kp_q  <= cfg_data;
					CFG_KI:  ki_q  <= cfg_data;
					CFG_KD:  kd_q  <= cfg_data;
					CFG_POS: pos_q <= cfg_data[RANGE_W-1:0];
					CFG_NEG: neg_q <= cfg_data[RANGE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_mag_q  <= err_mag;
			err_neg_q  <= err[ERR_W-1];
			diff_mag_q <= diff_mag;
			diff_neg_q <= diff[MAG_W-1];
		end
		case (state_q)
			ST_MUL_HI: acc_q <= ACC_W'(mul_p);
			ST_ACC:    acc_q <= acc_q + (ACC_W'(mul_p) << HALF_W);
			ST_SAT: begin
				if (term_q == TERM_P) p_term_q <= term_val;
				if (term_q == TERM_D) d_term_q <= term_val;
			end
			ST_SUM: sum_q <= SUM_W'(p_term_q) + SUM_W'(integral_q) + SUM_W'(d_term_q);
			ST_NORM: begin
				t_mag_q <= MAP_U_W'(sum_sat >> GAIN_FRAC_BITS);
				t_neg_q <= sum_q[SUM_W-1];
			end
			ST_MAP_DIV: begin
				x_q  <= MAP_X_W'(mul_p);
				qe_q <= RANGE_W'(rcp_prod >> MAP_SHIFT);
			end
			ST_MAP_FIX: q_q <= q_fix;
			ST_FINAL: begin
				if (fin_load) begin
					drive_q <= t_neg_q ? DRIVE_W'(q_q) - DRIVE_W'(neg_q) : DRIVE_W'(q_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import pcrm_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam longint ONE_Q = longint'(1) << GAIN_FRAC_BITS_DEF;
	localparam longint P_LIM_Q = P_LIM_INT * ONE_Q;
	localparam longint I_LIM_Q = I_LIM_INT * ONE_Q;
	localparam longint D_LIM_Q = D_LIM_INT * ONE_Q;
	localparam longint SUM_LIM_Q = SUM_LIM_INT * ONE_Q;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 143;
	localparam int MAX_REPORTS = 40;
	localparam int SETTLE_CYCLES = 24;
	localparam int EDGE_VALS [4] = '{-32768, 32767, 0, -1};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [DW-1:0]          setpoint;
	logic signed [DW-1:0]          measurement;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [DRIVE_W-1:0]     drive;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;

	pid_clamped_range_map dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.setpoint    (setpoint),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	class drive_scoreboard;
		logic [GAIN_W-1:0]         kp, ki, kd;
		logic [RANGE_W-1:0]        pos_rng, neg_rng;
		longint                    prev_err, integ;
		logic signed [DRIVE_W-1:0] drive_q [$];
		int                        mismatches, checked;

		function new();
			kp = KP_RESET;
			ki = KI_RESET;
			kd = KD_RESET;
			pos_rng = POS_RESET;
			neg_rng = NEG_RESET;
			prev_err = 0;
			integ = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_KP:  kp = val;
				CFG_KI:  ki = val;
				CFG_KD:  kd = val;
				CFG_POS: pos_rng = val[RANGE_W-1:0];
				CFG_NEG: neg_rng = val[RANGE_W-1:0];
				default: ;
			endcase
		endfunction

		static function longint clamp(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// products fit in 64 bits, so clamp the exact value
		function void note_sample(logic signed [DW-1:0] sp, logic signed [DW-1:0] ms);
			longint err, p, d, sum, t, drv;
			err = longint'(sp) - longint'(ms);
			p = clamp(longint'({1'b0, kp}) * err, P_LIM_Q);
			integ = clamp(integ + longint'({1'b0, ki}) * err, I_LIM_Q);
			d = clamp(longint'({1'b0, kd}) * (err - prev_err), D_LIM_Q);
			prev_err = err;
			sum = clamp(p + integ + d, SUM_LIM_Q);
			t = sum / ONE_Q;
			if (t > 0)
				drv = t * longint'({1'b0, pos_rng}) / MAP_FULL;
			else if (t < 0)
				drv = (t + MAP_FULL) * longint'({1'b0, neg_rng}) / MAP_FULL
					- longint'({1'b0, neg_rng});
			else
				drv = 0;
			drive_q.push_back(drv[DRIVE_W-1:0]);
		endfunction

		function void check_drive(logic signed [DRIVE_W-1:0] got);
			logic signed [DRIVE_W-1:0] want;
			checked++;
			if (drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: drive %0d with no sample outstanding", $time, got);
				return;
			end
			want = drive_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: drive mismatch, expected %0d, actual %0d",
						$time, want, got);
			end
		endfunction
	endclass

	drive_scoreboard sb;
	int tx_idle = 0;
	int rx_stall = 0;
	int n_sent = 0;
	int n_writes = 0;
	int cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall);
	end

	// outputs first: a drive leaving at this edge belongs to an older sample
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_drive(drive);
			if (in_valid && in_ready)
				sb.note_sample(setpoint, measurement);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic send_sample(input int sp, input int ms);
		in_valid <= 1'b1;
		setpoint <= sp[DW-1:0];
		measurement <= ms[DW-1:0];
		do @(posedge clk); while (!in_ready);
		n_sent++;
		if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		n_writes++;
	endtask

	// upper bits of the range words are noise; unused index goes last
	task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
		input logic [GAIN_W-1:0] kd, input logic [RANGE_W-1:0] pos,
		input logic [RANGE_W-1:0] neg);
		write_reg(CFG_KP, kp);
		write_reg(CFG_KI, ki);
		write_reg(CFG_KD, kd);
		write_reg(CFG_POS, {16'($urandom), pos});
		write_reg(CFG_NEG, {16'($urandom), neg});
		write_reg(CFG_IDX_W'(CFG_NEG + 1 + $urandom_range(0, 2)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.drive_q.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		int sp, ms, e, pick;
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		setpoint <= '0;
		measurement <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_KP;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains; errors sum to zero so the integral ends at zero
		send_sample(0, 0);
		send_sample(1, 0);
		send_sample(500, 0);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(-500, 0);
		send_sample(0, 1);
		send_sample(32767, 32767);
		send_sample(-32768, -32768);
		send_sample(1000, 0);
		send_sample(-1000, 0);

		// zero gains
		settle(SETTLE_CYCLES);
		apply_settings('0, '0, '0, 16'hFFFF, 16'hFFFF);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);

		// half gain: fractional sums and full-scale mapping
		settle(SETTLE_CYCLES);
		apply_settings(32'h0080_0000, '0, '0, 16'hFFFF, 16'hFFFF);
		send_sample(1, 0);
		send_sample(0, 1);
		send_sample(3, 0);
		send_sample(2000, 0);
		send_sample(-2000, 0);

		// huge products, zero ranges
		settle(SETTLE_CYCLES);
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
		send_sample(32767, -32768);
		send_sample(-5, 0);
		send_sample(0, 0);

		settle(SETTLE_CYCLES);
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle(SETTLE_CYCLES);
			case ((ph / 2 + ph) % 4)
				0: apply_settings($urandom_range(0, 32'h0400_0000),
					$urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0100_0000),
					16'($urandom), 16'($urandom));
				1: apply_settings($urandom, $urandom, $urandom, 16'($urandom),
					16'($urandom));
				2: apply_settings($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
					$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
					$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
					$urandom_range(1) ? 16'hFFFF : 16'h0,
					$urandom_range(1) ? 16'hFFFF : 16'h0);
				default: apply_settings($urandom_range(0, 32'h0080_0000),
					$urandom_range(32'h0010_0000, 32'h0400_0000),
					$urandom_range(0, 32'h0400_0000), 16'($urandom), 16'($urandom));
			endcase
			case (ph % 4)
				0: begin tx_idle = 0;  rx_stall = 0;  end
				1: begin tx_idle = 61; rx_stall = 0;  end
				2: begin tx_idle = 0;  rx_stall = 61; end
				default: begin tx_idle = 18; rx_stall = 18; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off until the pipeline is empty
				if (ph % 2 == 1 && i == PHASE_ITEMS / 2)
					settle(0);
				sp = $urandom_range(65535);
				sp -= 32768;
				pick = $urandom_range(9);
				if (pick <= 6) begin
					e = (pick <= 4) ? $urandom_range(4000) : $urandom_range(6);
					e -= (pick <= 4) ? 2000 : 3;
					ms = sp - e;
					if (ms > 32767 || ms < -32768)
						ms = sp + e;
				end else if (pick <= 8) begin
					ms = $urandom_range(65535);
					ms -= 32768;
				end else begin
					sp = EDGE_VALS[$urandom_range(3)];
					ms = EDGE_VALS[$urandom_range(3)];
				end
				send_sample(sp, ms);
			end
		end

		settle(SETTLE_CYCLES);
		$display("summary: %0d samples, %0d register writes, %0d drive values compared",
			n_sent, n_writes, sb.checked);
		$display("summary: directed extremes and gain corners, then %0d random phases",
			RAND_PHASES);
		if (sb.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/pcrm_pkg.sv
hw/rtl/pcrm_mul.sv
hw/rtl/pid_clamped_range_map.sv
test/testbench.sv
